// ----- src/sezc_pkg.sv -----
// shared constants and types for the screen edge zone coordinate unit
`default_nettype none
package sezc_pkg;

  // fixed field widths
  localparam int CNT_W      = 9;   // per-edge zone count
  localparam int MARG_W     = 11;  // one margin inside a margin register
  localparam int MARGS_W    = 22;  // a packed margin pair
  localparam int MODE_W     = 3;   // traversal mode
  localparam int ROT_W      = 11;  // signed index rotation
  localparam int ZONE_W     = 8;   // zone index field
  localparam int COORD_W    = 11;  // output coordinate fields
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  // magnitude of zone_index + rotation (range -1024 .. 1278)
  localparam int MAG_W = 11;
  localparam int SUM_W = MAG_W + 1;

  // traversal mode bits
  localparam int MODE_CCW_BIT = 2;

  // edge codes, canonical numbering
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_TOP    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT  = 2'd2;
  localparam logic [1:0] SIDE_BOTTOM = 2'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_CNT   = 3'd0,
    REG_TOP_CNT    = 3'd1,
    REG_RIGHT_CNT  = 3'd2,
    REG_BOTTOM_CNT = 3'd3,
    REG_HMARGINS   = 3'd4,
    REG_VMARGINS   = 3'd5,
    REG_MODE       = 3'd6,
    REG_ROTATION   = 3'd7
  } sezc_reg_t;

endpackage
`default_nettype wire

// ----- src/screen_edge_zone_coordinates_unit.sv -----
// top level: zone index to screen edge pixel coordinate, deep pipeline
// throughput: one beat per cycle; the modulo (3 stages) and divider (4 stages)
//   are fully pipelined, and a stall at the output freezes every stage
// reset: synchronous, clears all config registers and every pipeline valid bit
// derived config (order, kept counts, spans) settles in the cycle after a write
`default_nettype none
module screen_edge_zone_coordinates_unit #(
  parameter int ZONE_CAP  = 256,
  parameter int SCREEN_W  = 1920,
  parameter int SCREEN_H  = 1080
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input beats
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sezc_pkg::ZONE_W-1:0]      in_zone_index,
  // result beats
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [sezc_pkg::COORD_W-1:0]          out_pixel_x,
  output logic [sezc_pkg::COORD_W-1:0]          out_pixel_y,
  output logic                                  out_index_valid,
  // config writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sezc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sezc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sezc_pkg::*;

  // widths that follow from the parameters
  localparam int TOT_W  = $clog2(ZONE_CAP + 1);            // zone total
  localparam int KW     = (TOT_W > CNT_W) ? TOT_W : CNT_W;  // count vs room compare
  localparam int OKW    = (TOT_W > ZONE_W) ? TOT_W : ZONE_W;
  localparam int SCR_MX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
  localparam int SPAN_W = $clog2(SCR_MX);                   // holds SCREEN-1
  localparam int GW     = ((SPAN_W > MARG_W) ? SPAN_W : MARG_W) + 2;
  localparam int XW     = ((SPAN_W > COORD_W) ? SPAN_W : COORD_W) + 1;
  localparam int PROD_W = CNT_W + SPAN_W;

  // pipeline layout
  localparam int MOD_STG = 3;
  localparam int MSTEP   = (MAG_W + MOD_STG - 1) / MOD_STG;
  localparam int DIV_STG = 4;
  localparam int DSTEP   = (SPAN_W + DIV_STG - 1) / DIV_STG;
  localparam int ST_IN   = 0;
  localparam int ST_M0   = ST_IN + 1;
  localparam int ST_FIX  = ST_M0 + MOD_STG;
  localparam int ST_LOC  = ST_FIX + 1;
  localparam int ST_MUL  = ST_LOC + 1;
  localparam int ST_D0   = ST_MUL + 1;
  localparam int ST_OUT  = ST_D0 + DIV_STG;
  localparam int NSTG    = ST_OUT + 1;

  // one item as it moves down the pipe
  typedef struct packed {
    logic [ZONE_W-1:0]  zi;
    logic               neg;    // zone_index + rotation was negative
    logic [TOT_W-1:0]   mrem;   // modulo partial remainder
    logic [MAG_W-1:0]   mw;     // modulo dividend bits still to shift in
    logic               ok;     // index below the zone total
    logic [TOT_W-1:0]   m;      // rotated source position
    logic [1:0]         eg;     // edge code
    logic [CNT_W-1:0]   cnt;    // configured count of that edge
    logic [CNT_W-1:0]   t;      // point number along the canonical direction
    logic [CNT_W-1:0]   drem;   // divider partial remainder
    logic [SPAN_W-1:0]  dw;     // divider dividend bits, quotient shifts in
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } item_t;

  // config derived values, refreshed every cycle
  typedef struct packed {
    logic [3:0][1:0]       order;  // edge code at each traversal position
    logic [3:0][CNT_W-1:0] ocnt;   // configured count at each position
    logic [3:0][TOT_W-1:0] cum;    // running kept total, cum[3] is the total
    logic [SPAN_W-1:0]     spanx;
    logic [SPAN_W-1:0]     spany;
    logic [SPAN_W-1:0]     xr;
    logic [SPAN_W-1:0]     yb;
    logic [MARG_W-1:0]     ml;
    logic [MARG_W-1:0]     mt;
  } cfgd_t;

  // config registers
  logic [CNT_W-1:0]        cnt_left_r, cnt_top_r, cnt_right_r, cnt_bottom_r;
  logic [MARGS_W-1:0]      hmarg_r, vmarg_r;
  logic [MODE_W-1:0]       mode_r;
  logic signed [ROT_W-1:0] rot_r;

  cfgd_t derived_r, derived_nxt;

  item_t pipe_r   [NSTG];
  item_t pipe_nxt [NSTG];
  logic [NSTG-1:0] vld_r;
  logic            en;

  // the config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_left_r   <= '0;
      cnt_top_r    <= '0;
      cnt_right_r  <= '0;
      cnt_bottom_r <= '0;
      hmarg_r      <= '0;
      vmarg_r      <= '0;
      mode_r       <= '0;
      rot_r        <= '0;
    end else if (cfg_valid) begin
      unique case (sezc_reg_t'(cfg_index))
        REG_LEFT_CNT:   cnt_left_r   <= cfg_data[CNT_W-1:0];
        REG_TOP_CNT:    cnt_top_r    <= cfg_data[CNT_W-1:0];
        REG_RIGHT_CNT:  cnt_right_r  <= cfg_data[CNT_W-1:0];
        REG_BOTTOM_CNT: cnt_bottom_r <= cfg_data[CNT_W-1:0];
        REG_HMARGINS:   hmarg_r      <= cfg_data[MARGS_W-1:0];
        REG_VMARGINS:   vmarg_r      <= cfg_data[MARGS_W-1:0];
        REG_MODE:       mode_r       <= cfg_data[MODE_W-1:0];
        REG_ROTATION:   rot_r        <= cfg_data[ROT_W-1:0];
        default:        ;
      endcase
    end
  end

  // count of one edge by its code
  function automatic logic [CNT_W-1:0] edge_cnt_sel(
    input logic [1:0]       e,
    input logic [CNT_W-1:0] c_left,
    input logic [CNT_W-1:0] c_top,
    input logic [CNT_W-1:0] c_right,
    input logic [CNT_W-1:0] c_bottom
  );
    logic [CNT_W-1:0] c;
    unique case (e)
      SIDE_LEFT:   c = c_left;
      SIDE_TOP:    c = c_top;
      SIDE_RIGHT:  c = c_right;
      default:     c = c_bottom;
    endcase
    return c;
  endfunction

  // edge order, capacity cut and spans; only read from the second stage on,
  // so a write is seen by the very next accepted beat
  always_comb begin
    logic              rev;
    logic [1:0]        start;
    logic [1:0]        ord;
    logic [CNT_W-1:0]  oc;
    logic [TOT_W-1:0]  run;
    logic [TOT_W-1:0]  room;
    logic [TOT_W-1:0]  kept;
    logic [MARG_W-1:0] mr;
    logic [MARG_W-1:0] mb;
    logic signed [GW-1:0] dx, dy, dxr, dyb;

    derived_nxt = '0;
    rev   = mode_r[MODE_CCW_BIT];
    start = mode_r[1:0];
    run   = '0;
    for (int k = 0; k < 4; k++) begin
      // counterclockwise walks the edges backward
      ord  = rev ? 2'(start + 2'd3 - 2'(k)) : 2'(start + 2'(k));
      oc   = edge_cnt_sel(ord, cnt_left_r, cnt_top_r, cnt_right_r, cnt_bottom_r);
      room = TOT_W'(ZONE_CAP) - run;
      kept = (KW'(oc) < KW'(room)) ? TOT_W'(oc) : room;
      run  = run + kept;
      derived_nxt.order[k] = ord;
      derived_nxt.ocnt[k]  = oc;
      derived_nxt.cum[k]   = run;
    end

    derived_nxt.ml = hmarg_r[MARG_W-1:0];
    mr             = hmarg_r[2*MARG_W-1:MARG_W];
    derived_nxt.mt = vmarg_r[MARG_W-1:0];
    mb             = vmarg_r[2*MARG_W-1:MARG_W];

    dx  = GW'(SCREEN_W - 1) - GW'(derived_nxt.ml) - GW'(mr);
    dy  = GW'(SCREEN_H - 1) - GW'(derived_nxt.mt) - GW'(mb);
    dxr = GW'(SCREEN_W - 1) - GW'(mr);
    dyb = GW'(SCREEN_H - 1) - GW'(mb);
    // saturate at zero
    derived_nxt.spanx = dx[GW-1]  ? '0 : dx[SPAN_W-1:0];
    derived_nxt.spany = dy[GW-1]  ? '0 : dy[SPAN_W-1:0];
    derived_nxt.xr    = dxr[GW-1] ? '0 : dxr[SPAN_W-1:0];
    derived_nxt.yb    = dyb[GW-1] ? '0 : dyb[SPAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    derived_r <= derived_nxt;
  end

  // stage logic
  always_comb begin
    item_t                it;
    logic signed [SUM_W-1:0] sum;
    logic [TOT_W:0]       tmp_m;
    logic [CNT_W:0]       tmp_d;
    logic [1:0]           kk;
    logic [TOT_W-1:0]     base;
    logic [CNT_W-1:0]     i_loc;
    logic [SPAN_W-1:0]    span;
    logic [PROD_W-1:0]    prod;
    logic [XW-1:0]        xs, ys;

    tmp_m = '0;
    tmp_d = '0;

    // entry: zone_index + rotation, split into sign and magnitude
    it      = '0;
    it.zi   = in_zone_index;
    sum     = SUM_W'(signed'({1'b0, in_zone_index})) + SUM_W'(rot_r);
    it.neg  = sum[SUM_W-1];
    it.mw   = it.neg ? MAG_W'(-sum) : sum[MAG_W-1:0];
    it.mrem = '0;
    pipe_nxt[ST_IN] = it;

    // restoring remainder of the magnitude by the total
    for (int s = 0; s < MOD_STG; s++) begin
      it = pipe_r[ST_M0 + s - 1];
      for (int j = 0; j < MSTEP; j++) begin
        if (s * MSTEP + j < MAG_W) begin
          tmp_m = {it.mrem, it.mw[MAG_W-1]};
          it.mw = {it.mw[MAG_W-2:0], 1'b0};
          if (tmp_m >= {1'b0, derived_r.cum[3]}) begin
            it.mrem = TOT_W'(tmp_m - {1'b0, derived_r.cum[3]});
          end else begin
            it.mrem = tmp_m[TOT_W-1:0];
          end
        end
      end
      pipe_nxt[ST_M0 + s] = it;
    end

    // true modulo for a negative sum, and the range check
    it    = pipe_r[ST_FIX - 1];
    it.m  = (it.neg && (it.mrem != '0)) ? TOT_W'(derived_r.cum[3] - it.mrem) : it.mrem;
    it.ok = (OKW'(it.zi) < OKW'(derived_r.cum[3]));
    pipe_nxt[ST_FIX] = it;

    // find the traversal position, then the point along the canonical direction
    it = pipe_r[ST_LOC - 1];
    priority if (it.m < derived_r.cum[0]) kk = 2'd0;
    else if (it.m < derived_r.cum[1])     kk = 2'd1;
    else if (it.m < derived_r.cum[2])     kk = 2'd2;
    else                                  kk = 2'd3;
    base   = (kk == 2'd0) ? '0 : derived_r.cum[kk - 2'd1];
    i_loc  = CNT_W'(it.m - base);
    it.eg  = derived_r.order[kk];
    it.cnt = derived_r.ocnt[kk];
    it.t   = mode_r[MODE_CCW_BIT] ? CNT_W'(it.cnt - 1'b1 - i_loc) : i_loc;
    pipe_nxt[ST_LOC] = it;

    // t * span, split into divider high part and shift-in bits
    it   = pipe_r[ST_MUL - 1];
    span = ((it.eg == SIDE_LEFT) || (it.eg == SIDE_RIGHT)) ?
           derived_r.spany : derived_r.spanx;
    prod = PROD_W'(it.t) * PROD_W'(span);
    it.drem = prod[PROD_W-1:SPAN_W];
    it.dw   = prod[SPAN_W-1:0];
    pipe_nxt[ST_MUL] = it;

    // restoring division by the edge count, quotient collects in dw
    for (int s = 0; s < DIV_STG; s++) begin
      it = pipe_r[ST_D0 + s - 1];
      for (int j = 0; j < DSTEP; j++) begin
        if (s * DSTEP + j < SPAN_W) begin
          tmp_d = {it.drem, it.dw[SPAN_W-1]};
          if (tmp_d >= {1'b0, it.cnt}) begin
            it.drem = CNT_W'(tmp_d - {1'b0, it.cnt});
            it.dw   = {it.dw[SPAN_W-2:0], 1'b1};
          end else begin
            it.drem = tmp_d[CNT_W-1:0];
            it.dw   = {it.dw[SPAN_W-2:0], 1'b0};
          end
        end
      end
      pipe_nxt[ST_D0 + s] = it;
    end

    // place the point on its edge
    it = pipe_r[ST_OUT - 1];
    unique case (it.eg)
      SIDE_LEFT: begin
        xs = XW'(derived_r.ml);
        ys = XW'(derived_r.yb) - XW'(it.dw);
      end
      SIDE_TOP: begin
        xs = XW'(derived_r.ml) + XW'(it.dw);
        ys = XW'(derived_r.mt);
      end
      SIDE_RIGHT: begin
        xs = XW'(derived_r.xr);
        ys = XW'(derived_r.mt) + XW'(it.dw);
      end
      default: begin
        xs = XW'(derived_r.xr) - XW'(it.dw);
        ys = XW'(derived_r.yb);
      end
    endcase
    // out of range index gives a zero coordinate
    it.x = it.ok ? xs[COORD_W-1:0] : '0;
    it.y = it.ok ? ys[COORD_W-1:0] : '0;
    pipe_nxt[ST_OUT] = it;
  end

  // whole pipe advances unless the output register holds an untaken beat
  assign en       = !vld_r[NSTG-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign out_valid       = vld_r[NSTG-1];
  assign out_pixel_x     = pipe_r[ST_OUT].x;
  assign out_pixel_y     = pipe_r[ST_OUT].y;
  assign out_index_valid = pipe_r[ST_OUT].ok;

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_index_valid) |-> (out_pixel_x == '0 && out_pixel_y == '0))
    else $error("out of range beat with nonzero coordinate");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[ST_IN])
    else $error("accepted beat missing from entry stage");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (vld_r == $past(vld_r)))
    else $error("pipe valid bits moved during a stall");

endmodule
`default_nettype wire

// ----- verif/sezc_checker.sv -----
// checker for the zone coordinate unit: mirrors the setup, predicts each point, compares beats
module sezc_checker #(
  parameter int ZONE_CAP  = 256,
  parameter int SCREEN_W  = 1920,
  parameter int SCREEN_H  = 1080
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic [sezc_pkg::ZONE_W-1:0]      in_zone_index,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic [sezc_pkg::COORD_W-1:0]     out_pixel_x,
  input  wire logic [sezc_pkg::COORD_W-1:0]     out_pixel_y,
  input  wire logic                             out_index_valid,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [sezc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sezc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                    fail_count,
  output int                                    pending_points
);
  import sezc_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               hit;
  } zone_point_t;

  // mirrored setup registers
  logic [CNT_W-1:0]   edge_count [4];
  logic [MARGS_W-1:0] hmarg_reg;
  logic [MARGS_W-1:0] vmarg_reg;
  logic [MODE_W-1:0]  mode_reg;
  logic [ROT_W-1:0]   rot_reg;

  zone_point_t expected_points [$];

  initial begin
    fail_count     = 0;
    pending_points = 0;
  end

  function automatic int floor0(input int v);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic zone_point_t zone_point(input logic [ZONE_W-1:0] zi);
    zone_point_t pt;
    logic [1:0]  order [4];
    int          kept [4];
    logic        ccw;
    logic [1:0]  corner;
    int          total, room, cnt, sel, src, t, off, rot;
    int          m_left, m_right, m_top, m_bottom;
    int          span_x, span_y, x_right, y_bottom, px, py;
    ccw    = mode_reg[MODE_CCW_BIT];
    corner = mode_reg[1:0];
    total  = 0;
    // edge order from the start corner, each edge clipped to what room is left
    for (int k = 0; k < 4; k++) begin
      room     = ZONE_CAP - total;
      order[k] = ccw ? (corner + 2'd3 - 2'(k)) : (corner + 2'(k));
      cnt      = int'(edge_count[order[k]]);
      kept[k]  = (cnt < room) ? cnt : room;
      total   += kept[k];
    end
    pt = '0;
    if (total == 0 || int'(zi) >= total)
      return pt;
    rot = int'($signed(rot_reg));
    off = rot % total;
    if (off < 0)
      off += total;
    src = (int'(zi) + off) % total;
    m_left   = int'(hmarg_reg[MARG_W-1:0]);
    m_right  = int'(hmarg_reg[MARGS_W-1:MARG_W]);
    m_top    = int'(vmarg_reg[MARG_W-1:0]);
    m_bottom = int'(vmarg_reg[MARGS_W-1:MARG_W]);
    span_x   = floor0(SCREEN_W - 1 - m_left - m_right);
    span_y   = floor0(SCREEN_H - 1 - m_top - m_bottom);
    x_right  = floor0(SCREEN_W - 1 - m_right);
    y_bottom = floor0(SCREEN_H - 1 - m_bottom);
    sel = 0;
    while (sel < 3 && src >= kept[sel]) begin
      src -= kept[sel];
      sel++;
    end
    // spacing always follows the full configured count
    cnt = int'(edge_count[order[sel]]);
    t   = ccw ? (cnt - 1 - src) : src;
    case (order[sel])
      SIDE_LEFT: begin
        px = m_left;
        py = y_bottom - (t * span_y) / cnt;
      end
      SIDE_TOP: begin
        px = m_left + (t * span_x) / cnt;
        py = m_top;
      end
      SIDE_RIGHT: begin
        px = x_right;
        py = m_top + (t * span_y) / cnt;
      end
      default: begin
        px = x_right - (t * span_x) / cnt;
        py = y_bottom;
      end
    endcase
    pt.x   = px[COORD_W-1:0];
    pt.y   = py[COORD_W-1:0];
    pt.hit = 1'b1;
    return pt;
  endfunction

  task automatic check_field(input string field, input logic [COORD_W-1:0] want,
                             input logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    zone_point_t want;
    if (!rst_n) begin
      foreach (edge_count[e])
        edge_count[e] = '0;
      hmarg_reg = '0;
      vmarg_reg = '0;
      mode_reg  = '0;
      rot_reg   = '0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT_CNT:   edge_count[SIDE_LEFT]   = cfg_data[CNT_W-1:0];
          REG_TOP_CNT:    edge_count[SIDE_TOP]    = cfg_data[CNT_W-1:0];
          REG_RIGHT_CNT:  edge_count[SIDE_RIGHT]  = cfg_data[CNT_W-1:0];
          REG_BOTTOM_CNT: edge_count[SIDE_BOTTOM] = cfg_data[CNT_W-1:0];
          REG_HMARGINS:   hmarg_reg = cfg_data[MARGS_W-1:0];
          REG_VMARGINS:   vmarg_reg = cfg_data[MARGS_W-1:0];
          REG_MODE:       mode_reg  = cfg_data[MODE_W-1:0];
          default:        rot_reg   = cfg_data[ROT_W-1:0];
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("result beat with no zone query waiting: x %0d y %0d valid %0b",
                 out_pixel_x, out_pixel_y, out_index_valid);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("pixel_x", want.x, out_pixel_x);
          check_field("pixel_y", want.y, out_pixel_y);
          check_field("index_valid", COORD_W'(want.hit), COORD_W'(out_index_valid));
        end
      end
      if (in_valid && in_ready)
        expected_points.push_back(zone_point(in_zone_index));
    end
    pending_points = expected_points.size();
  end

endmodule

// ----- verif/testbench.sv -----
// top of the zone coordinate unit bench: clock, reset, setup writes, query and result traffic
module testbench;
  import sezc_pkg::*;

  localparam int ZONE_CAP      = 256;
  localparam int SCREEN_W      = 1920;
  localparam int SCREEN_H      = 1080;
  localparam int LATENCY       = 11;    // sizes the closing wait for stray beats
  localparam int SETTLE_CYCLES = 3;     // derived setup settles in the cycle after a write
  localparam int LONG_HOLD     = 300;   // receiver back-pressure stretch
  localparam int STALL_LIMIT   = 4000;  // cycles with no beat on any channel
  localparam int RANDOM_ITEMS  = 1000;

  // receiver behavior, picked anew at random once the current style runs out
  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_PATTERN
  } sink_style_t;

  // one complete register setting
  typedef struct packed {
    logic [3:0][CNT_W-1:0] counts;   // indexed by edge code
    logic [MARGS_W-1:0]    hmarg;    // {right, left}
    logic [MARGS_W-1:0]    vmarg;    // {bottom, top}
    logic [MODE_W-1:0]     mode;
    logic [ROT_W-1:0]      rot;
  } zone_setup_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [ZONE_W-1:0]     in_zone_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [COORD_W-1:0]    out_pixel_x;
  logic [COORD_W-1:0]    out_pixel_y;
  logic                  out_index_valid;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_points;
  int hold_requests;    // bumped by the sender side to ask for a long receiver hold

  screen_edge_zone_coordinates_unit #(
    .ZONE_CAP  (ZONE_CAP),
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_zone_index   (in_zone_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_index_valid (out_index_valid),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // passive side: watches all three channels and scores every result beat
  sezc_checker #(
    .ZONE_CAP  (ZONE_CAP),
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H)
  ) i_zone_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_zone_index   (in_zone_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_index_valid (out_index_valid),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_points  (pending_points)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: own stall pattern, plus the long hold when asked for
  initial begin : result_sink
    sink_style_t style;
    int          style_left;
    int          hold_left;
    int          holds_seen;
    style      = SINK_OPEN;
    style_left = 0;
    hold_left  = 0;
    holds_seen = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (style_left == 0) begin
        style      = sink_style_t'($urandom_range(SINK_OPEN, SINK_PATTERN));
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      if (hold_left > 0) begin
        // counted here so the sender keeps pushing and the pipe backs up
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (style)
          SINK_OPEN:  out_ready <= 1'b1;
          SINK_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          SINK_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= style_left[1];
        endcase
      end
    end
  end

  // no beat on any channel for too long means the block is hung
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // all stimulus tasks start and end just after a falling edge

  // offer one query beat and hold it until taken; valid stays up afterwards
  task automatic send_item(input logic [ZONE_W-1:0] zone);
    in_valid      <= 1'b1;
    in_zone_index <= zone;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int gap);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // sender sits idle until every query has come back
  task automatic drain_results();
    while (pending_points != 0) @(negedge clk);
  endtask

  // write all eight registers back to back, only with the block empty
  task automatic apply_setup(input zone_setup_t s);
    logic [CFG_DATA_W-1:0] data;
    in_valid <= 1'b0;
    drain_results();
    for (int r = REG_LEFT_CNT; r <= REG_ROTATION; r++) begin
      case (r)
        REG_LEFT_CNT:   data = CFG_DATA_W'(s.counts[SIDE_LEFT]);
        REG_TOP_CNT:    data = CFG_DATA_W'(s.counts[SIDE_TOP]);
        REG_RIGHT_CNT:  data = CFG_DATA_W'(s.counts[SIDE_RIGHT]);
        REG_BOTTOM_CNT: data = CFG_DATA_W'(s.counts[SIDE_BOTTOM]);
        REG_HMARGINS:   data = s.hmarg;
        REG_VMARGINS:   data = s.vmarg;
        REG_MODE:       data = CFG_DATA_W'(s.mode);
        default:        data = CFG_DATA_W'(s.rot);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r[CFG_IDX_W-1:0];
      cfg_data  <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    // let the derived edge order and spans catch up before querying
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    zone_setup_t       setup;
    int                items_left;
    int                phase_no;
    int                n;
    int                burst;
    int                total_est;
    logic              gapless;
    logic              squeeze;
    logic [ZONE_W-1:0] zi;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_zone_index = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_requests = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers still at reset: zero zones, every index is out of range
    send_item(8'd0);
    send_item(8'd255);

    // every extreme at once: oversized counts cut at capacity, margins that
    // swallow the whole screen, counterclockwise from bottom right, and a
    // rotation of -1023, one above the field's most negative value
    setup.counts[SIDE_LEFT]   = 9'd511;
    setup.counts[SIDE_TOP]    = 9'd511;
    setup.counts[SIDE_RIGHT]  = 9'd511;
    setup.counts[SIDE_BOTTOM] = 9'd511;
    setup.hmarg = {11'd2047, 11'd2047};
    setup.vmarg = {11'd2047, 11'd2047};
    setup.mode  = 3'd7;
    setup.rot   = 11'h401;
    apply_setup(setup);
    send_item(8'd0);
    send_item(8'd128);
    send_item(8'd255);

    // top edge, after the full left edge, cut partway by capacity, largest
    // positive rotation, and indexes at the edge boundary and at the last zone
    setup.counts[SIDE_LEFT]   = 9'd200;
    setup.counts[SIDE_TOP]    = 9'd200;
    setup.counts[SIDE_RIGHT]  = 9'd7;
    setup.counts[SIDE_BOTTOM] = 9'd0;
    setup.hmarg = '0;
    setup.vmarg = '0;
    setup.mode  = 3'd0;
    setup.rot   = 11'h3FF;
    apply_setup(setup);
    send_item(8'd0);
    send_item(8'd199);
    send_item(8'd200);
    send_item(8'd255);

    // each start corner in both directions, first and last zone
    setup.counts[SIDE_LEFT]   = 9'd3;
    setup.counts[SIDE_TOP]    = 9'd2;
    setup.counts[SIDE_RIGHT]  = 9'd4;
    setup.counts[SIDE_BOTTOM] = 9'd1;
    setup.hmarg = {11'd7, 11'd5};
    setup.vmarg = {11'd11, 11'd9};
    setup.rot   = '0;
    for (int m = 0; m < 8; m++) begin
      setup.mode = m[MODE_W-1:0];
      apply_setup(setup);
      send_item(8'd0);
      send_item(8'd9);
    end

    // random phases: fresh setting each time, mostly in-range indexes
    items_left = RANDOM_ITEMS;
    phase_no   = 0;
    while (items_left > 0) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 9))
          0:       setup.counts[k] = '0;
          1:       setup.counts[k] = CNT_W'($urandom_range(257, 511));
          2:       setup.counts[k] = CNT_W'($urandom_range(100, 256));
          default: setup.counts[k] = CNT_W'($urandom_range(1, 40));
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        setup.hmarg = MARGS_W'($urandom);
        setup.vmarg = MARGS_W'($urandom);
      end else begin
        setup.hmarg = {MARG_W'($urandom_range(0, 300)), MARG_W'($urandom_range(0, 300))};
        setup.vmarg = {MARG_W'($urandom_range(0, 300)), MARG_W'($urandom_range(0, 300))};
      end
      setup.mode = MODE_W'($urandom_range(0, 7));
      // half full-range rotations, half small ones around zero
      if ($urandom_range(0, 1) == 0)
        setup.rot = ROT_W'($urandom);
      else
        setup.rot = ROT_W'($urandom_range(0, 40) - 20);
      apply_setup(setup);

      total_est = 0;
      for (int k = 0; k < 4; k++)
        total_est += int'(setup.counts[k]);
      if (total_est > ZONE_CAP)
        total_est = ZONE_CAP;

      // the second phase runs the receiver hold with a continuous sender
      squeeze = (phase_no == 1);
      gapless = squeeze || ($urandom_range(0, 3) == 0);
      n = squeeze ? 100 : $urandom_range(30, 120);
      if (n > items_left)
        n = items_left;
      if (squeeze)
        hold_requests++;

      while (n > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > n)
          burst = n;
        repeat (burst) begin
          if (total_est > 0 && $urandom_range(0, 99) < 85)
            zi = ZONE_W'($urandom_range(0, total_est - 1));
          else
            zi = ZONE_W'($urandom_range(0, 255));
          send_item(zi);
        end
        n          -= burst;
        items_left -= burst;
        if (!gapless)
          pause_sender($urandom_range(1, 10));
      end
      phase_no++;
    end

    // wind down: everything back, then an extra wait for stray beats
    in_valid <= 1'b0;
    drain_results();
    repeat (3 * LATENCY) @(negedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/sezc_pkg.sv
src/screen_edge_zone_coordinates_unit.sv
verif/sezc_checker.sv
verif/testbench.sv
